// ===== rtl/core/pas_pkg.sv =====
// types, widths and codes shared by the polygon area statistics block
package pas_pkg;

  localparam int FIELD_W    = 16;
  localparam int COORD_BITS = 16;
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int ACC_W      = 48;
  localparam int AREA_W     = 42;
  localparam int CNT_W      = 16;
  localparam int SUM_W      = 64;
  localparam int PCNT_W     = 32;

  localparam int IN_DATA_W  = 2 * FIELD_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT = 1'b1;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  typedef enum logic [1:0] {
    FILT_ALL   = 2'd0,
    FILT_EVEN  = 2'd1,
    FILT_ODD   = 2'd2,
    FILT_EXACT = 2'd3
  } filter_mode_t;

  // first member sits in the highest bits
  typedef struct packed {
    logic [PCNT_W-1:0] polygons_seen;
    logic [CNT_W-1:0]  fewest_vertices;
    logic [CNT_W-1:0]  most_vertices;
    logic [AREA_W-1:0] smallest_area;
    logic [AREA_W-1:0] largest_area;
    logic [SUM_W-1:0]  total_area_sum;
    logic [PCNT_W-1:0] filtered_polygon_count;
    logic [SUM_W-1:0]  filtered_area_sum;
    logic              matches_filter;
    logic [CNT_W-1:0]  vertex_count;
    logic [AREA_W-1:0] twice_area;
  } result_t;

  localparam int RESULT_W   = $bits(result_t);
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/core/pas_result_fifo.sv =====
// two-entry result buffer with registered ready toward the pipeline
module pas_result_fifo
  import pas_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    head_valid,
  output result_t head_data,
  input  logic    head_ready
);

  logic [1:0] cnt_r, cnt_nxt;
  result_t    head_r, head_nxt;
  result_t    spare_r, spare_nxt;
  logic       pop;

  assign pop        = (cnt_r != 2'd0) && head_ready;
  assign push_ready = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = head_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    spare_nxt = spare_r;
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          head_nxt = push_data;
        end else begin
          spare_nxt = push_data;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        head_nxt = spare_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_nxt = push_data;
        end else begin
          head_nxt  = spare_r;
          spare_nxt = push_data;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
  end

endmodule

// ===== rtl/core/polygon_area_statistics.sv =====
// polygon area statistics top level: shoelace area pipeline and running stats
//
// in_*: one vertex per transfer, x in in_tdata[15:0], y in in_tdata[31:16],
// in_tlast on the last vertex of each polygon. every polygon yields one
// transfer on out_*: twice its area, its vertex count, the filter match and
// the running statistics over all polygons closed so far.
// cfg_*: filter mode (index 0) and exact filter count (index 1), written
// while the stream is idle.
// throughput: one vertex per cycle unless a stall holds the ring stage; the products
// of a vertex and of the closing edge are formed in one stage and summed into the ring
// total in the next. after the last vertex transfer the result passes the input,
// product, ring sum, area and result buffer registers before it is on out_tvalid.
// reset clears the ring state, the statistics (minimums to all ones) and the
// pipeline; the filter returns to all polygons with count 3.
// a stalled receiver fills the two-entry result buffer and the area stages;
// the next closing vertex then waits in the ring stage and in_tready drops;
// no result is lost or repeated.
module polygon_area_statistics
  import pas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // x_coord, y_coord
  input  logic                  in_tlast,   // last_vertex
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // twice_area, vertex_count, matches_filter, filtered_area_sum,
  // filtered_polygon_count, total_area_sum, largest_area, smallest_area,
  // most_vertices, fewest_vertices, polygons_seen, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  filter_mode_t     mode_r;
  logic [CNT_W-1:0] fcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= FILT_ALL;
      fcount_r <= CNT_W'(3);
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_FILTER_MODE) begin
        mode_r <= filter_mode_t'(cfg_data[1:0]);
      end else begin
        fcount_r <= cfg_data[CNT_W-1:0];
      end
    end
  end

  // pipeline flow control
  logic v1_r, v2_r, v3_r, v4_r;
  logic last1_r, last2_r;
  logic fifo_ready, go1, go2, go3, go4, rdy2, rdy3, rdy4, in_xfer;

  assign rdy4      = !v4_r || fifo_ready;
  assign go4       = v4_r && fifo_ready;
  assign rdy3      = !v3_r || rdy4;
  assign go3       = v3_r && rdy4;
  assign go2       = v2_r && (!last2_r || rdy3);
  assign rdy2      = !v2_r || go2;
  assign go1       = v1_r && rdy2;
  assign in_tready = !v1_r || go1;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        v1_r <= 1'b1;
      end else if (go1) begin
        v1_r <= 1'b0;
      end
      if (go1) begin
        v2_r <= 1'b1;
      end else if (go2) begin
        v2_r <= 1'b0;
      end
      if (go2 && last2_r) begin
        v3_r <= 1'b1;
      end else if (go3) begin
        v3_r <= 1'b0;
      end
      if (go3) begin
        v4_r <= 1'b1;
      end else if (go4) begin
        v4_r <= 1'b0;
      end
    end
  end

  // input register
  logic signed [COORD_BITS-1:0] x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x1_r    <= signed'(in_tdata[COORD_BITS-1:0]);
      y1_r    <= signed'(in_tdata[FIELD_W+COORD_BITS-1:FIELD_W]);
      last1_r <= in_tlast;
    end
  end

  // ring state and products
  logic                         mid_r;
  logic signed [COORD_BITS-1:0] start_x_r, start_y_r, prior_x_r, prior_y_r;
  logic signed [COORD_BITS-1:0] sx_eff, sy_eff;
  logic [CNT_W-1:0]             vcnt_r, vcnt_nxt;

  assign sx_eff   = mid_r ? start_x_r : x1_r;
  assign sy_eff   = mid_r ? start_y_r : y1_r;
  assign vcnt_nxt = !mid_r ? CNT_W'(1) : ((vcnt_r == '1) ? vcnt_r : vcnt_r + CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r     <= 1'b0;
      vcnt_r    <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
      prior_x_r <= '0;
      prior_y_r <= '0;
    end else if (go1) begin
      mid_r     <= !last1_r;
      vcnt_r    <= vcnt_nxt;
      start_x_r <= sx_eff;
      start_y_r <= sy_eff;
      prior_x_r <= x1_r;
      prior_y_r <= y1_r;
    end
  end

  logic signed [PROD_W-1:0] p1_r, q1_r, p2_r, q2_r;
  logic                     first2_r;
  logic [CNT_W-1:0]         n2_r;

  always_ff @(posedge clk) begin
    if (go1) begin
      p1_r     <= prior_x_r * y1_r;
      q1_r     <= x1_r * prior_y_r;
      p2_r     <= x1_r * sy_eff;
      q2_r     <= sx_eff * y1_r;
      first2_r <= !mid_r;
      last2_r  <= last1_r;
      n2_r     <= vcnt_nxt;
    end
  end

  // ring sum
  logic signed [PROD_W:0] edge_term, close_term;
  logic [ACC_W-1:0]       acc_r, acc_base, edge_ext, close_ext, acc_sum;
  logic [ACC_W-1:0]       acc3_r;
  logic [CNT_W-1:0]       n3_r;

  assign edge_term  = PROD_W'(p1_r) - PROD_W'(q1_r) == 0 ? '0
                      : (PROD_W+1)'(p1_r) - (PROD_W+1)'(q1_r);
  assign close_term = (PROD_W+1)'(p2_r) - (PROD_W+1)'(q2_r);
  assign edge_ext   = first2_r ? '0
                      : {{(ACC_W-PROD_W-1){edge_term[PROD_W]}}, edge_term};
  assign close_ext  = last2_r ? {{(ACC_W-PROD_W-1){close_term[PROD_W]}}, close_term} : '0;
  assign acc_base   = first2_r ? '0 : acc_r;
  assign acc_sum    = acc_base + edge_ext + close_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (go2) begin
      acc_r <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (go2 && last2_r) begin
      acc3_r <= acc_sum;
      n3_r   <= n2_r;
    end
  end

  // magnitude and filter
  logic [ACC_W-1:0]  acc_abs;
  logic [AREA_W-1:0] mag3, mag4_r;
  logic              match3, match4_r;
  logic [CNT_W-1:0]  n4_r;

  assign acc_abs = acc3_r[ACC_W-1] ? (ACC_W'(0) - acc3_r) : acc3_r;
  assign mag3    = (|acc_abs[ACC_W-1:AREA_W]) ? AREA_MAX : acc_abs[AREA_W-1:0];

  always_comb begin
    unique case (mode_r)
      FILT_ALL:   match3 = 1'b1;
      FILT_EVEN:  match3 = !n3_r[0];
      FILT_ODD:   match3 = n3_r[0];
      FILT_EXACT: match3 = (n3_r == fcount_r);
      default:    match3 = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      mag4_r   <= mag3;
      n4_r     <= n3_r;
      match4_r <= match3;
    end
  end

  // running statistics
  logic [SUM_W-1:0]  fsum_r, tsum_r;
  logic [PCNT_W-1:0] fcnt_r, pcnt_r;
  logic [AREA_W-1:0] max_area_r, min_area_r;
  logic [CNT_W-1:0]  max_vert_r, min_vert_r;
  logic [SUM_W:0]    fsum_add, tsum_add;
  result_t           res_nxt, res_out;

  assign fsum_add = {1'b0, fsum_r} + (SUM_W+1)'(mag4_r);
  assign tsum_add = {1'b0, tsum_r} + (SUM_W+1)'(mag4_r);

  always_comb begin
    res_nxt.twice_area     = mag4_r;
    res_nxt.vertex_count   = n4_r;
    res_nxt.matches_filter = match4_r;
    res_nxt.filtered_area_sum = !match4_r ? fsum_r
                                : (fsum_add[SUM_W] ? '1 : fsum_add[SUM_W-1:0]);
    res_nxt.filtered_polygon_count = (match4_r && (fcnt_r != '1))
                                     ? fcnt_r + PCNT_W'(1) : fcnt_r;
    res_nxt.total_area_sum  = tsum_add[SUM_W] ? '1 : tsum_add[SUM_W-1:0];
    res_nxt.largest_area    = (mag4_r > max_area_r) ? mag4_r : max_area_r;
    res_nxt.smallest_area   = (mag4_r < min_area_r) ? mag4_r : min_area_r;
    res_nxt.most_vertices   = (n4_r > max_vert_r) ? n4_r : max_vert_r;
    res_nxt.fewest_vertices = (n4_r < min_vert_r) ? n4_r : min_vert_r;
    res_nxt.polygons_seen   = (pcnt_r != '1) ? pcnt_r + PCNT_W'(1) : pcnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsum_r     <= '0;
      fcnt_r     <= '0;
      tsum_r     <= '0;
      max_area_r <= '0;
      min_area_r <= '1;
      max_vert_r <= '0;
      min_vert_r <= '1;
      pcnt_r     <= '0;
    end else if (go4) begin
      fsum_r     <= res_nxt.filtered_area_sum;
      fcnt_r     <= res_nxt.filtered_polygon_count;
      tsum_r     <= res_nxt.total_area_sum;
      max_area_r <= res_nxt.largest_area;
      min_area_r <= res_nxt.smallest_area;
      max_vert_r <= res_nxt.most_vertices;
      min_vert_r <= res_nxt.fewest_vertices;
      pcnt_r     <= res_nxt.polygons_seen;
    end
  end

  pas_result_fifo u_result_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (go4),
    .push_data  (res_nxt),
    .push_ready (fifo_ready),
    .head_valid (out_tvalid),
    .head_data  (res_out),
    .head_ready (out_tready)
  );

  assign out_tdata = {{(OUT_DATA_W-RESULT_W){1'b0}}, res_out};

`ifndef SYNTHESIS
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r != '0) |-> (min_area_r <= max_area_r) && (min_vert_r <= max_vert_r))
    else $error("area or vertex minimum above maximum");

  a_fcnt_le_pcnt: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= pcnt_r)
    else $error("filtered polygon count above polygon count");

  a_fsum_le_tsum: assert property (@(posedge clk) disable iff (!rst_n)
    fsum_r <= tsum_r)
    else $error("filtered area sum above total area sum");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (go2 && last2_r) |-> (!v3_r || go3))
    else $error("closed ring overwrote a pending area stage");
`endif

endmodule
